[src/lssd_pkg.sv]
// Shared types, codes and the scan response descriptor table for the scan deframer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package lssd_pkg;

	// Reset value of the bad-node limit register.
	localparam logic [7:0] MaxBadNodesReset = 8'd5;

	// Length of the scan response descriptor and the last index into it.
	localparam int unsigned DescLen = 7;
	localparam logic [2:0] DescLast = 3'(DescLen - 1);

	// Node byte that completes a node (bytes 0..3 are stored first).
	localparam logic [2:0] NodeLast = 3'd4;

	localparam logic [7:0] BadCountMax = 8'hFF;

	// Input operation codes.
	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_DESC_OK  = 3'd0;
	localparam logic [2:0] ST_DESC_BAD = 3'd1;
	localparam logic [2:0] ST_POINT    = 3'd2;
	localparam logic [2:0] ST_TOO_BAD  = 3'd3;
	localparam logic [2:0] ST_TIMEOUT  = 3'd4;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DESC  = 2'd1,
		PH_NODES = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [14:0] angle_q6;
		logic [15:0] distance_q2;
		logic [5:0]  quality;
		logic        new_rotation;
	} out_item_t;

	// A result from the deframer core: whether the current word produces one, and its fields.
	typedef struct packed {
		logic      valid;
		out_item_t item;
	} result_t;

	// Expected descriptor byte at a given position.
	function automatic logic [7:0] desc_byte(input logic [2:0] idx);
		logic [7:0] val;
		begin
			unique case (idx)
				3'd0: val = 8'hA5;
				3'd1: val = 8'h5A;
				3'd2: val = 8'h05;
				3'd3: val = 8'h00;
				3'd4: val = 8'h00;
				3'd5: val = 8'h40;
				3'd6: val = 8'h81;
				default: val = 8'h81;
			endcase
			return val;
		end
	endfunction

endpackage
`default_nettype wire

[src/lssd_core.sv]
// Deframer core: phase, byte index, node buffer and bad-node counter, plus the
// combinational result for the word held in the input stage. Depends on lssd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lssd_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire lssd_pkg::in_item_t word,
	input  wire logic [7:0]        max_bad_nodes,
	output lssd_pkg::result_t      res
);
	import lssd_pkg::*;

	phase_t     phase_q, phase_d;
	logic [2:0] byte_index_q, byte_index_d;
	logic       mismatch_q, mismatch_d;
	logic [7:0] bad_cnt_q, bad_cnt_d;
	logic [7:0] node_q [4];

	logic [2:0]  desc_idx;
	logic        mismatch_any;
	logic [15:0] node_dist;
	logic [14:0] ang;
	logic        node_good;
	logic [7:0]  bad_inc;
	logic [7:0]  b0;
	logic [7:0]  b1;

	assign b0       = node_q[0];
	assign b1       = node_q[1];
	assign node_dist = {word.rx_byte, node_q[3]};
	assign ang      = {node_q[2], b1[7:1]};
	assign node_good = (b0[0] ^ b0[1]) && b1[0] && (node_dist != 16'd0);
	assign bad_inc  = (bad_cnt_q < BadCountMax) ? bad_cnt_q + 8'd1 : bad_cnt_q;
	assign desc_idx = (byte_index_q > DescLast) ? DescLast : byte_index_q;
	assign mismatch_any = mismatch_q | (word.rx_byte != desc_byte(desc_idx));

	// Next state.
	always_comb begin
		phase_d      = phase_q;
		byte_index_d = byte_index_q;
		mismatch_d   = mismatch_q;
		bad_cnt_d    = bad_cnt_q;
		unique case (word.op)
			OP_RESTART: begin
				phase_d      = PH_DESC;
				byte_index_d = 3'd0;
				mismatch_d   = 1'b0;
				bad_cnt_d    = 8'd0;
			end
			OP_TIMEOUT: begin
				if (phase_q == PH_DESC) begin
					phase_d      = PH_IDLE;
					byte_index_d = 3'd0;
				end else if (phase_q == PH_NODES) begin
					byte_index_d = 3'd0;
					bad_cnt_d    = 8'd0;
				end
			end
			OP_BYTE: begin
				if (phase_q == PH_DESC) begin
					mismatch_d = mismatch_any;
					if (desc_idx < DescLast) begin
						byte_index_d = desc_idx + 3'd1;
					end else begin
						byte_index_d = 3'd0;
						phase_d      = mismatch_any ? PH_IDLE : PH_NODES;
					end
				end else if (phase_q == PH_NODES) begin
					if (byte_index_q < NodeLast) begin
						byte_index_d = byte_index_q + 3'd1;
					end else begin
						byte_index_d = 3'd0;
						if (node_good) begin
							bad_cnt_d = 8'd0;
						end else if (bad_inc >= max_bad_nodes) begin
							bad_cnt_d = 8'd0;
						end else begin
							bad_cnt_d = bad_inc;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result for the current word.
	always_comb begin
		res = '0;
		unique case (word.op)
			OP_TIMEOUT: begin
				if (phase_q == PH_DESC || phase_q == PH_NODES) begin
					res.valid       = 1'b1;
					res.item.status = ST_TIMEOUT;
				end
			end
			OP_BYTE: begin
				if (phase_q == PH_DESC && desc_idx == DescLast) begin
					res.valid       = 1'b1;
					res.item.status = mismatch_any ? ST_DESC_BAD : ST_DESC_OK;
				end else if (phase_q == PH_NODES && byte_index_q >= NodeLast) begin
					if (node_good) begin
						res.valid             = 1'b1;
						res.item.status       = ST_POINT;
						res.item.angle_q6     = ang;
						res.item.distance_q2  = node_dist;
						res.item.quality      = b0[7:2];
						res.item.new_rotation = b0[0];
					end else if (bad_inc >= max_bad_nodes) begin
						res.valid       = 1'b1;
						res.item.status = ST_TOO_BAD;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			byte_index_q <= 3'd0;
			mismatch_q   <= 1'b0;
			bad_cnt_q    <= 8'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			byte_index_q <= byte_index_d;
			mismatch_q   <= mismatch_d;
			bad_cnt_q    <= bad_cnt_d;
		end
	end

	// Node buffer: payload only, written before it is read within a frame.
	always_ff @(posedge clk) begin
		if (step && word.op == OP_BYTE && phase_q == PH_NODES && byte_index_q < NodeLast) begin
			node_q[byte_index_q[1:0]] <= word.rx_byte;
		end
	end

`ifndef SYNTHESIS
	a_restart_enters_desc: assert property (@(posedge clk) disable iff (!arst_n)
		step && word.op == OP_RESTART |=> phase_q == PH_DESC && byte_index_q == 3'd0
			&& bad_cnt_q == 8'd0)
		else $error("restart did not enter descriptor phase cleanly");
	a_idle_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> byte_index_q == 3'd0)
		else $error("byte index nonzero while idle");
	a_node_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_NODES |-> byte_index_q <= NodeLast)
		else $error("node byte index out of range");
	a_too_bad_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.item.status == ST_TOO_BAD |=> bad_cnt_q == 8'd0)
		else $error("bad-node count not cleared after failure result");
`endif
endmodule
`default_nettype wire

[src/lssd_out_reg.sv]
// Result register of the scan deframer: holds one result word until the sink takes it.
// Depends on lssd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lssd_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire lssd_pkg::out_item_t load_item,
	output logic                    free,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output lssd_pkg::out_item_t     out_item
);
	import lssd_pkg::*;

	logic      valid_q;
	out_item_t item_q;

	// The register can take a new result when empty or when its word leaves this cycle.
	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= load_item;
		end
	end
endmodule
`default_nettype wire

[src/lidar_scan_stream_deframer_unit.sv]
// Top level of the scan response deframer: input stage, limit register, core and
// result register. Depends on lssd_pkg, lssd_core and lssd_out_reg.
// An accepted word is registered in the input stage, and its result in the result register, ahead of the out port.
// Throughput: one word per cycle while the sink does not stall.
// Reset (arst_n low, asynchronous) empties both stages, sets the phase to idle, clears the
// byte index and bad-node count, and sets the bad-node limit to 5.
`timescale 1ns / 1ps
`default_nettype none
module lidar_scan_stream_deframer_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire lssd_pkg::in_item_t in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output lssd_pkg::out_item_t     out_item,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_data
);
	import lssd_pkg::*;

	// Input stage. A word sits here while the core evaluates it, until it retires.
	logic     valid_s1;
	in_item_t item_s1;

	logic       cfg_write;
	logic [7:0] max_bad_nodes_q;
	result_t    res;
	logic       out_free;
	logic       step;
	logic       in_take;

	// The limit register is always writable; the user must write it only while the block is idle (not enforced here).
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bad_nodes_q <= MaxBadNodesReset;
		end else if (cfg_write) begin
			max_bad_nodes_q <= cfg_data;
		end
	end

	// The word in the input stage retires when it makes no result, or when the result
	// register has room for the one it makes. State in the core updates on that edge.
	assign step     = valid_s1 && (!res.valid || out_free);
	assign in_stall = valid_s1 && !step;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	lssd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.word         (item_s1),
		.max_bad_nodes(max_bad_nodes_q),
		.res          (res)
	);

	lssd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && res.valid),
		.load_item(res.item),
		.free     (out_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);
endmodule
`default_nettype wire
